/* hw/rtl/lgst_pkg.sv */
// Shared types and constants for the light gate speed trap.
// No dependencies; imported by light_gate_speed_trap.
package lgst_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CMD_W        = 2;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 40;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  localparam int LIMIT_W      = 7;
  localparam int DNUM_W       = 16;
  localparam int FIELD_W      = 16;
  localparam int DIV_STEPS    = FIELD_W;
  localparam int STEP_W       = $clog2(DIV_STEPS);

  typedef logic [CMD_W-1:0]       cmd_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cmd_t CMD_TICK   = 2'd0;
  localparam cmd_t CMD_SENSOR = 2'd1;
  localparam cmd_t CMD_REMOTE = 2'd2;

  localparam logic KIND_LOCAL  = 1'b0;
  localparam logic KIND_REMOTE = 1'b1;

  localparam cfg_index_t REG_SPEED_LIMIT = 2'd0;
  localparam cfg_index_t REG_DIST_NUM    = 2'd1;

  localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = 7'd50;
  localparam logic [DNUM_W-1:0]  DIST_NUM_RST    = 16'd45720;
  localparam logic [FIELD_W-1:0] FIELD_TOP       = 16'hFFFF;

endpackage

/* hw/rtl/light_gate_speed_trap.sv */
// Two-gate speed trap: tick counting, gate sensing, serial speed divider.
// Depends on lgst_pkg.
// Ticks, start-gate sensor requests and ignored requests are handled in the
// idle state. A remote speed request passes to the pending state before its
// result is registered. An end-gate request is accepted, then runs 16
// iterations of the restoring divide step (one quotient bit each), then moves
// the result to the output register; with a zero count the divider is skipped.
// The block takes no request from acceptance until its result has entered the
// output register, which then holds it until the sink takes it.
module light_gate_speed_trap #(
  parameter int COUNT_WIDTH = lgst_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [0] start_blocked, [1] end_blocked, [17:2] remote_speed, [23:18] zero
  input  logic [lgst_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] cmd
  input  logic [lgst_pkg::CMD_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] elapsed_ms, [31:16] speed_mm_s, [32] divide_error,
  // [33] over_limit, [39:34] zero
  output logic [lgst_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] result_kind
  output logic                              out_tuser,
  input  logic                              cfg_wen,
  input  logic [lgst_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lgst_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lgst_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PEND = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic                   timing_r, timing_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [LIMIT_W-1:0]     limit_r;
  logic [DNUM_W-1:0]      dnum_r;
  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [FIELD_W-1:0]     quo_r, quo_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic                   pend_kind_r, pend_kind_nxt;
  logic                   pend_over_r, pend_over_nxt;
  logic                   pend_derr_r, pend_derr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_kind_r, out_kind_nxt;

  logic                   start_b, end_b;
  logic [FIELD_W-1:0]     remote;
  logic [LIMIT_W+3:0]     limit_x10;
  logic [COUNT_WIDTH:0]   trial;
  logic [COUNT_WIDTH:0]   diff;
  logic [31:0]            count_ext;
  logic [FIELD_W-1:0]     shown;
  logic                   out_free;

  assign start_b   = in_tdata[0];
  assign end_b     = in_tdata[1];
  assign remote    = in_tdata[17:2];
  assign limit_x10 = {1'b0, limit_r, 3'b000} + {3'b000, limit_r, 1'b0};

  // restoring divide step
  assign trial = {rem_r, quo_r[FIELD_W-1]};
  assign diff  = trial - {1'b0, count_r};

  assign count_ext = 32'(count_r);
  assign shown     = (count_ext > 32'(FIELD_TOP)) ? FIELD_TOP : count_ext[FIELD_W-1:0];
  assign out_free  = !out_valid_r || out_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  always_comb begin
    state_nxt     = state_r;
    timing_nxt    = timing_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    pend_kind_nxt = pend_kind_r;
    pend_over_nxt = pend_over_r;
    pend_derr_nxt = pend_derr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_kind_nxt  = out_kind_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            CMD_TICK: begin
              if (timing_r && (count_r != '1)) begin
                count_nxt = count_r + COUNT_WIDTH'(1);
              end
            end
            CMD_SENSOR: begin
              if (start_b) begin
                count_nxt  = '0;
                timing_nxt = 1'b1;
              end else if (end_b) begin
                timing_nxt    = 1'b0;
                pend_kind_nxt = KIND_LOCAL;
                pend_over_nxt = 1'b0;
                if (count_r == '0) begin
                  pend_derr_nxt = 1'b1;
                  quo_nxt       = '0;
                  state_nxt     = ST_PEND;
                end else begin
                  pend_derr_nxt = 1'b0;
                  quo_nxt       = dnum_r;
                  rem_nxt       = '0;
                  step_nxt      = '0;
                  state_nxt     = ST_DIV;
                end
              end
            end
            CMD_REMOTE: begin
              pend_kind_nxt = KIND_REMOTE;
              pend_over_nxt = remote > FIELD_W'(limit_x10);
              pend_derr_nxt = 1'b0;
              quo_nxt       = '0;
              state_nxt     = ST_PEND;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (!diff[COUNT_WIDTH]) begin
          rem_nxt = diff[COUNT_WIDTH-1:0];
          quo_nxt = {quo_r[FIELD_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[COUNT_WIDTH-1:0];
          quo_nxt = {quo_r[FIELD_W-2:0], 1'b0};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_PEND;
        end
      end
      ST_PEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pend_kind_r;
          if (pend_kind_r == KIND_REMOTE) begin
            out_data_nxt = {6'b0, pend_over_r, 1'b0, {FIELD_W{1'b0}}, {FIELD_W{1'b0}}};
          end else begin
            out_data_nxt = {6'b0, 1'b0, pend_derr_r, quo_r, shown};
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      timing_r    <= 1'b0;
      count_r     <= '0;
      limit_r     <= SPEED_LIMIT_RST;
      dnum_r      <= DIST_NUM_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      timing_r    <= timing_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen && (cfg_index == REG_SPEED_LIMIT)) begin
        limit_r <= cfg_wdata[LIMIT_W-1:0];
      end
      if (cfg_wen && (cfg_index == REG_DIST_NUM)) begin
        dnum_r <= cfg_wdata[DNUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    step_r      <= step_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_over_r <= pend_over_nxt;
    pend_derr_r <= pend_derr_nxt;
    out_data_r  <= out_data_nxt;
    out_kind_r  <= out_kind_nxt;
  end

  a_derr_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> out_tdata[31:16] == '0)
    else $error("divide error with nonzero speed");

  a_remote_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_REMOTE) |-> out_tdata[32:0] == '0)
    else $error("remote result carries local fields");

  a_start_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_SENSOR) && in_tdata[0]
    |=> timing_r && (count_r == '0))
    else $error("start gate did not restart timing");

  a_div_ends_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && (step_r == STEP_W'(DIV_STEPS - 1)) |=> state_r == ST_PEND)
    else $error("divider did not hand off result");

endmodule
